[rtl/protobuf_field_tokenizer_assert.svh]
// Assertion macros used by the checker of the field tokenizer.
`ifndef PROTOBUF_FIELD_TOKENIZER_ASSERT_SVH
`define PROTOBUF_FIELD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PFT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pft_pkg.sv]
package pft_pkg;

    localparam int LEN_W = 21;
    localparam logic [63:0] MAX_PAYLOAD = 64'd1048576;

    // Front queue geometry
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    // Result queue geometry
    localparam int RQ_DEPTH = 2;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // Result kinds
    localparam logic [2:0] K_VARINT  = 3'd0;
    localparam logic [2:0] K_FIX32   = 3'd1;
    localparam logic [2:0] K_FIX64   = 3'd2;
    localparam logic [2:0] K_PAYLOAD = 3'd3;
    localparam logic [2:0] K_EMPTY   = 3'd4;
    localparam logic [2:0] K_ERROR   = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [28:0]      field_number;
        logic [63:0]      value;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] length;
        logic             field_done;
        logic             message_end;
    } out_item_t;

    // Byte as classified by the front end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ends;
    } tok_t;

endpackage

[rtl/pft_front.sv]
module pft_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  pft_pkg::in_item_t item,
    input  logic             tok_pop,
    output logic             tok_valid,
    output pft_pkg::tok_t    tok
);

    pft_pkg::tok_t                 mem_reg [pft_pkg::FQ_DEPTH];
    logic [pft_pkg::FQ_AW-1:0]     wr_reg;
    logic [pft_pkg::FQ_AW-1:0]     wr_next;
    logic [pft_pkg::FQ_AW-1:0]     rd_reg;
    logic [pft_pkg::FQ_AW-1:0]     rd_next;
    logic [pft_pkg::FQ_CW-1:0]     cnt_reg;
    logic [pft_pkg::FQ_CW-1:0]     cnt_next;
    logic                          do_push;
    logic                          do_pop;
    pft_pkg::tok_t                 cls;

    // A varint group ends on a clear continuation bit or at the buffer end
    assign cls.data = item.in_byte;
    assign cls.last = item.msg_last;
    assign cls.ends = !item.in_byte[7] || item.msg_last;

    assign full      = (cnt_reg == pft_pkg::FQ_CW'(pft_pkg::FQ_DEPTH));
    assign tok_valid = (cnt_reg != '0);
    assign tok       = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = tok_pop && tok_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/pft_back.sv]
module pft_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  pft_pkg::tok_t      tok,
    output logic               tok_pop,
    input  logic               res_space,
    output logic               res_push,
    output pft_pkg::out_item_t res
);

    localparam logic [2:0] PH_KEY     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIX64   = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_FIX32   = 3'd5;

    localparam logic [6:0] SHIFT_CAP = 7'd64;

    logic [2:0]                phase_reg, phase_next;
    logic [31:0]               key_reg, key_next;
    logic [6:0]                shift_reg, shift_next;
    logic [63:0]               val_reg, val_next;
    logic [2:0]                wire_reg, wire_next;
    logic [28:0]               field_reg, field_next;
    logic [pft_pkg::LEN_W-1:0] left_reg, left_next;
    logic [pft_pkg::LEN_W-1:0] dlen_reg, dlen_next;
    logic                      disc_reg, disc_next;

    logic        fire;
    logic        fixed_ph;
    logic [7:0]  operand;
    logic [63:0] shifted;
    logic [7:0]  sum7;
    logic [7:0]  sum8;
    logic [6:0]  inc7;
    logic [6:0]  inc8;
    logic        emit_mid;
    logic        finish;
    logic        fail;
    logic        left_le1;

    assign fire     = tok_valid && res_space;
    assign tok_pop  = fire;
    assign fixed_ph = (phase_reg == PH_FIX32) || (phase_reg == PH_FIX64);
    assign operand  = fixed_ph ? tok.data : {1'b0, tok.data[6:0]};
    assign shifted  = {56'd0, operand} << shift_reg[5:0];
    assign sum7     = {1'b0, shift_reg} + 8'd7;
    assign sum8     = {1'b0, shift_reg} + 8'd8;
    assign inc7     = (sum7 > {1'b0, SHIFT_CAP}) ? SHIFT_CAP : sum7[6:0];
    assign inc8     = (sum8 > {1'b0, SHIFT_CAP}) ? SHIFT_CAP : sum8[6:0];
    assign left_le1 = (left_reg <= pft_pkg::LEN_W'(1));
    assign res_push = fire && (emit_mid || finish || fail);

    always_comb
    begin
        phase_next = phase_reg;
        key_next   = key_reg;
        shift_next = shift_reg;
        val_next   = val_reg;
        wire_next  = wire_reg;
        field_next = field_reg;
        left_next  = left_reg;
        dlen_next  = dlen_reg;
        disc_next  = disc_reg;
        emit_mid   = 1'b0;
        finish     = 1'b0;
        fail       = 1'b0;
        res        = '0;

        if (fire)
        begin
            if (disc_reg)
            begin
                // Drop bytes until the buffer ends, then start afresh
                if (tok.last)
                begin
                    phase_next = PH_KEY;
                    key_next   = '0;
                    shift_next = '0;
                    val_next   = '0;
                    wire_next  = '0;
                    field_next = '0;
                    left_next  = '0;
                    dlen_next  = '0;
                    disc_next  = 1'b0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_KEY:
                    begin
                        key_next   = key_reg | ((shift_reg < 7'd32) ? shifted[31:0] : 32'd0);
                        shift_next = inc7;
                        if (tok.ends)
                        begin
                            field_next = key_next[31:3];
                            wire_next  = key_next[2:0];
                            key_next   = '0;
                            shift_next = '0;
                            val_next   = '0;
                            if (tok.last)
                            begin
                                if (wire_next == 3'd0)
                                begin
                                    finish   = 1'b1;
                                    res.kind = pft_pkg::K_VARINT;
                                end
                                else if (wire_next == 3'd2)
                                begin
                                    finish   = 1'b1;
                                    res.kind = pft_pkg::K_EMPTY;
                                end
                                else
                                begin
                                    fail = 1'b1;
                                end
                            end
                            else
                            begin
                                case (wire_next)
                                    3'd0:    phase_next = PH_VARINT;
                                    3'd1:
                                    begin
                                        phase_next = PH_FIX64;
                                        left_next  = pft_pkg::LEN_W'(8);
                                    end
                                    3'd2:    phase_next = PH_LEN;
                                    3'd5:
                                    begin
                                        phase_next = PH_FIX32;
                                        left_next  = pft_pkg::LEN_W'(4);
                                    end
                                    default: fail = 1'b1;
                                endcase
                            end
                        end
                    end

                    PH_VARINT, PH_LEN:
                    begin
                        val_next = val_reg | (!shift_reg[6] ? shifted : 64'd0);
                        if (phase_reg == PH_LEN && shift_reg >= 7'd63 && tok.data[6:0] != 7'd0)
                        begin
                            val_next = '1;
                        end
                        shift_next = inc7;
                        if (tok.ends)
                        begin
                            if (phase_reg == PH_VARINT)
                            begin
                                finish    = 1'b1;
                                res.kind  = pft_pkg::K_VARINT;
                                res.value = val_next;
                            end
                            else if (val_next == 64'd0)
                            begin
                                finish   = 1'b1;
                                res.kind = pft_pkg::K_EMPTY;
                            end
                            else if (val_next > pft_pkg::MAX_PAYLOAD || tok.last)
                            begin
                                fail = 1'b1;
                            end
                            else
                            begin
                                dlen_next  = val_next[pft_pkg::LEN_W-1:0];
                                left_next  = val_next[pft_pkg::LEN_W-1:0];
                                key_next   = '0;
                                shift_next = '0;
                                val_next   = '0;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end

                    PH_PAYLOAD:
                    begin
                        if (left_le1)
                        begin
                            left_next     = '0;
                            finish        = 1'b1;
                            res.kind      = pft_pkg::K_PAYLOAD;
                            res.data_byte = tok.data;
                            res.length    = dlen_reg;
                        end
                        else if (tok.last)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            left_next     = left_reg - 1'b1;
                            emit_mid      = 1'b1;
                            res.kind      = pft_pkg::K_PAYLOAD;
                            res.data_byte = tok.data;
                            res.length    = dlen_reg;
                        end
                    end

                    PH_FIX32, PH_FIX64:
                    begin
                        if (phase_reg == PH_FIX32 && shift_reg < 7'd32)
                        begin
                            val_next = val_reg | shifted;
                        end
                        shift_next = inc8;
                        if (left_le1)
                        begin
                            left_next = '0;
                            finish    = 1'b1;
                            if (phase_reg == PH_FIX32)
                            begin
                                res.kind  = pft_pkg::K_FIX32;
                                res.value = {32'd0, val_next[31:0]};
                            end
                            else
                            begin
                                res.kind = pft_pkg::K_FIX64;
                            end
                        end
                        else if (tok.last)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            left_next = left_reg - 1'b1;
                        end
                    end

                    default:
                    begin
                        phase_next = PH_KEY;
                        key_next   = '0;
                        shift_next = '0;
                        val_next   = '0;
                        wire_next  = '0;
                        field_next = '0;
                        left_next  = '0;
                        dlen_next  = '0;
                        disc_next  = 1'b0;
                    end
                endcase
            end
        end

        if (finish || fail)
        begin
            key_next   = '0;
            shift_next = '0;
            val_next   = '0;
            phase_next = PH_KEY;
        end
        if (fail)
        begin
            left_next = '0;
            dlen_next = '0;
            disc_next = !tok.last;
            res       = '0;
            res.kind  = pft_pkg::K_ERROR;
        end
        res.field_number = field_next;
        res.field_done   = finish;
        res.message_end  = (finish || fail) && tok.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY;
            key_reg   <= '0;
            shift_reg <= '0;
            val_reg   <= '0;
            wire_reg  <= '0;
            field_reg <= '0;
            left_reg  <= '0;
            dlen_reg  <= '0;
            disc_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
            shift_reg <= shift_next;
            val_reg   <= val_next;
            wire_reg  <= wire_next;
            field_reg <= field_next;
            left_reg  <= left_next;
            dlen_reg  <= dlen_next;
            disc_reg  <= disc_next;
        end
    end

endmodule

[rtl/pft_outq.sv]
module pft_outq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_push,
    input  pft_pkg::out_item_t res,
    output logic               res_space,
    output logic               empty,
    input  logic               pop,
    output pft_pkg::out_item_t result
);

    pft_pkg::out_item_t        mem_reg [pft_pkg::RQ_DEPTH];
    logic [pft_pkg::RQ_AW-1:0] wr_reg, wr_next;
    logic [pft_pkg::RQ_AW-1:0] rd_reg, rd_next;
    logic [pft_pkg::RQ_CW-1:0] cnt_reg, cnt_next;
    logic                      do_push;
    logic                      do_pop;

    assign res_space = (cnt_reg != pft_pkg::RQ_CW'(pft_pkg::RQ_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign result    = mem_reg[rd_reg];
    assign do_push   = res_push && res_space;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/protobuf_field_tokenizer.sv]
// Protobuf wire-format field tokenizer. Feed the encoded message one byte per
// request through the push/full port, with msg_last set on the buffer's last
// byte; collect tokens through the empty/pop port. Varint fields (wire type 0)
// report their value, fixed32 fields (type 5) report their little-endian
// value, fixed64 fields (type 1) report one skipped token after 8 bytes, and
// length-delimited fields (type 2) give one token per payload byte with
// field_done set on the final one, or an empty-field token for length zero.
// Bad wire types, lengths above 1 MiB, and fixed-width fields or non-empty
// payloads cut short by the buffer end give an error token; after an error
// not on the last byte, every byte up to and including the last one is
// dropped silently. Throughput is one byte per clock while the result queue
// has room: the parser updates its accumulators and counters once per byte.
// An accepted byte waits in a 4-entry byte queue, is parsed from there, and
// its token, if any, goes into a 2-entry result queue that feeds the result
// port, so either side may stall without stopping the other at once.
module protobuf_field_tokenizer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  pft_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output pft_pkg::out_item_t result
);

    logic               tok_valid;
    logic               tok_pop;
    pft_pkg::tok_t      tok;
    logic               res_space;
    logic               res_push;
    pft_pkg::out_item_t res;

    // Front: take requests, mark where each varint group ends, hold in queue
    pft_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .tok_pop   (tok_pop),
        .tok_valid (tok_valid),
        .tok       (tok)
    );

    // Back: run the wire-format state machine, one byte per cycle while the
    // result queue has room
    pft_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .res_space (res_space),
        .res_push  (res_push),
        .res       (res)
    );

    // Result queue: hold tokens until the consumer pops them
    pft_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .res_space (res_space),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

[rtl/pft_checker.sv]
`include "protobuf_field_tokenizer_assert.svh"

module pft_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input pft_pkg::out_item_t result
);

    `PFT_ASSERT_NEXT(a_hold_result, clk, rst_n, !empty && !pop, !empty && $stable(result), "result changed while stalled")
    `PFT_ASSERT_IMPLY(a_kind_range, clk, rst_n, !empty, result.kind <= pft_pkg::K_ERROR, "result kind out of range")
    `PFT_ASSERT_IMPLY(a_error_not_done, clk, rst_n, !empty && result.kind == pft_pkg::K_ERROR, !result.field_done, "error marked as field done")
    `PFT_ASSERT_IMPLY(a_payload_only_data, clk, rst_n, !empty && result.kind != pft_pkg::K_PAYLOAD, result.data_byte == 8'd0 && result.length == '0, "data or length on non-payload token")
    `PFT_ASSERT_IMPLY(a_value_only_num, clk, rst_n, !empty && result.kind != pft_pkg::K_VARINT && result.kind != pft_pkg::K_FIX32, result.value == 64'd0, "value on non-numeric token")

endmodule

bind protobuf_field_tokenizer pft_checker u_pft_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
